@@ hdl/ames_pkg.sv @@
// Shared constants, codes and control types of the adjacency-matrix edge store.
package ames_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int WEIGHT_BITS  = 16;

   localparam int VID_W     = $clog2(MAX_VERTICES);
   localparam int VCNT_W    = VID_W + 1;
   localparam int FUNC_W    = 3;
   localparam int STATUS_W  = 2;
   localparam int WEIGHT_W  = 16;
   localparam int ECNT_W    = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = VCNT_W;

   // Row scan is split into groups: find the lowest hit per group, then the lowest group.
   localparam int GRP_SIZE  = 8;
   localparam int GRP_W     = $clog2(GRP_SIZE);
   localparam int GRP_COUNT = MAX_VERTICES / GRP_SIZE;
   localparam int GSEL_W    = VID_W - GRP_W;

   localparam logic [ECNT_W-1:0] ECNT_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTED     = 1'b1;

   typedef enum logic [FUNC_W-1:0] {
      FN_INSERT = 3'd0,
      FN_REMOVE = 3'd1,
      FN_QUERY  = 3'd2,
      FN_FIRST  = 3'd3,
      FN_NEXT   = 3'd4,
      FN_CLEAR  = 3'd5
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE       = 2'd0,
      ST_NO_EDGE    = 2'd1,
      ST_BAD_VERTEX = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_EXEC,
      S_SCAN,
      S_MIRROR_RD,
      S_MIRROR_WR,
      S_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic early;
      logic rd_u;
      logic exec;
      logic pick;
      logic rd_v;
      logic wr_v;
      logic deliver;
   } ctrl_cmd_type;

   typedef struct packed {
      logic go_mem;
      logic is_scan;
      logic mirror;
   } dp_stat_type;

endpackage

@@ hdl/ames_ctrl.sv @@
// Sequencer of the edge store: steps each word through decode, row access and result.
module ames_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  rsp_free,
   input  ames_pkg::dp_stat_type stat,
   output ames_pkg::ctrl_cmd_type cmd
);
   import ames_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.go_mem) begin
               cmd.rd_u = 1'b1;
               state_in = S_EXEC;
            end else begin
               cmd.early = 1'b1;
               state_in  = S_DONE;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.is_scan) begin
               state_in = S_SCAN;
            end else if (stat.mirror) begin
               state_in = S_MIRROR_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            cmd.pick = 1'b1;
            state_in = S_DONE;
         end
         S_MIRROR_RD: begin
            cmd.rd_v = 1'b1;
            state_in = S_MIRROR_WR;
         end
         S_MIRROR_WR: begin
            cmd.wr_v = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               cmd.deliver = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ hdl/ames_datapath.sv @@
// Datapath of the edge store: row memory, row valid bits, edge counter and row scan.
module ames_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  ames_pkg::ctrl_cmd_type              cmd,
   output ames_pkg::dp_stat_type               stat,
   input  logic [ames_pkg::FUNC_W-1:0]         req_func,
   input  logic [ames_pkg::VID_W-1:0]          req_src_vertex,
   input  logic [ames_pkg::VID_W-1:0]          req_dst_vertex,
   input  logic signed [ames_pkg::WEIGHT_W-1:0] req_edge_weight,
   input  logic [ames_pkg::VCNT_W-1:0]         vcount,
   input  logic                                directed,
   output logic [ames_pkg::STATUS_W-1:0]       res_status,
   output logic [ames_pkg::VID_W-1:0]          res_neighbour,
   output logic                                res_adjacent,
   output logic [ames_pkg::ECNT_W-1:0]         edge_count
);
   import ames_pkg::*;

   // Captured operation
   logic [FUNC_W-1:0] func_ff;
   logic [VID_W-1:0]  u_ff;
   logic [VID_W-1:0]  v_ff;
   logic              present_ff;
   logic              present_in;
   logic [31:0]       wext;

   // Row memory: one presence bit per column
   logic [MAX_VERTICES-1:0] row_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] row_valid_ff;
   logic [MAX_VERTICES-1:0] rd_data_ff;
   logic                    rd_valid_ff;
   logic [MAX_VERTICES-1:0] rd_row;
   logic [MAX_VERTICES-1:0] wr_row;
   logic [VID_W-1:0]        rd_addr;
   logic [VID_W-1:0]        wr_addr;
   logic                    rd_en;
   logic                    wr_en;
   logic                    hit;
   logic                    new_bit;
   logic                    changes_u;
   logic                    do_clear;

   logic uok;
   logic vok;
   logic is_mem;
   logic op_ok;

   logic [ECNT_W-1:0] ecnt_ff;

   // Scan
   logic [VCNT_W-1:0]       start;
   logic [MAX_VERTICES-1:0] cand;
   logic [GRP_COUNT-1:0]    grp_any_ff;
   logic [GRP_COUNT-1:0]    grp_any_in;
   logic [GRP_W-1:0]        grp_low_ff [GRP_COUNT];
   logic [GRP_W-1:0]        grp_low_in [GRP_COUNT];
   logic                    found;
   logic [VID_W-1:0]        found_idx;

   // Result
   status_type        res_status_ff;
   status_type        exec_status;
   logic [VID_W-1:0]  res_nb_ff;
   logic              res_adj_ff;

   assign wext       = {{(32 - WEIGHT_W){req_edge_weight[WEIGHT_W-1]}}, req_edge_weight};
   assign present_in = (wext[WEIGHT_BITS-1:0] != {WEIGHT_BITS{1'b1}});

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff    <= req_func;
         u_ff       <= req_src_vertex;
         v_ff       <= req_dst_vertex;
         present_ff <= present_in;
      end
   end

   // Vertex checks
   assign uok    = ({1'b0, u_ff} < vcount);
   assign vok    = ({1'b0, v_ff} < vcount);
   assign is_mem = func_ff inside {FN_INSERT, FN_REMOVE, FN_QUERY, FN_FIRST, FN_NEXT};

   always_comb begin
      case (func_ff)
         FN_FIRST: op_ok = uok;
         default:  op_ok = uok && vok;
      endcase
   end

   // Row access
   assign rd_en     = cmd.rd_u || cmd.rd_v;
   assign rd_addr   = cmd.rd_v ? v_ff : u_ff;
   assign rd_row    = rd_valid_ff ? rd_data_ff : '0;
   assign hit       = rd_row[v_ff];
   assign new_bit   = (func_ff == FN_INSERT) && present_ff;
   assign changes_u = (func_ff == FN_INSERT) || ((func_ff == FN_REMOVE) && hit);
   assign wr_en     = (cmd.exec && changes_u) || cmd.wr_v;
   assign wr_addr   = cmd.wr_v ? v_ff : u_ff;
   assign do_clear  = cmd.early && (func_ff == FN_CLEAR);

   always_comb begin
      wr_row = rd_row;
      if (cmd.wr_v) begin
         wr_row[u_ff] = new_bit;
      end else begin
         wr_row[v_ff] = new_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_data_ff  <= row_mem[rd_addr];
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   // A row not written since the last clear reads as empty
   always_ff @(posedge clock) begin
      if (reset || do_clear) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || do_clear) begin
         ecnt_ff <= '0;
      end else if (cmd.exec) begin
         if ((func_ff == FN_INSERT) && (ecnt_ff != ECNT_MAX)) begin
            ecnt_ff <= ecnt_ff + 1'b1;
         end else if ((func_ff == FN_REMOVE) && hit && (ecnt_ff != '0)) begin
            ecnt_ff <= ecnt_ff - 1'b1;
         end
      end
   end

   // Scan: mask the row to [start, vcount), then lowest hit per group
   assign start = (func_ff == FN_FIRST) ? '0 : ({1'b0, v_ff} + 1'b1);

   always_comb begin
      for (int j = 0; j < MAX_VERTICES; j++) begin
         cand[j] = rd_row[j] && (VCNT_W'(j) >= start) && (VCNT_W'(j) < vcount);
      end
      for (int g = 0; g < GRP_COUNT; g++) begin
         grp_any_in[g] = |cand[g*GRP_SIZE +: GRP_SIZE];
         grp_low_in[g] = '0;
         for (int k = GRP_SIZE - 1; k >= 0; k--) begin
            if (cand[g*GRP_SIZE + k]) begin
               grp_low_in[g] = GRP_W'(k);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         grp_any_ff <= grp_any_in;
         grp_low_ff <= grp_low_in;
      end
   end

   always_comb begin
      found     = 1'b0;
      found_idx = '0;
      for (int g = GRP_COUNT - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            found     = 1'b1;
            found_idx = {GSEL_W'(g), grp_low_ff[g]};
         end
      end
   end

   // Result
   always_comb begin
      case (func_ff)
         FN_REMOVE: exec_status = hit ? ST_DONE : ST_NO_EDGE;
         default:   exec_status = ST_DONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.early) begin
         res_status_ff <= is_mem ? ST_BAD_VERTEX : ST_DONE;
         res_nb_ff     <= '0;
         res_adj_ff    <= 1'b0;
      end else if (cmd.exec) begin
         res_status_ff <= exec_status;
         res_nb_ff     <= '0;
         res_adj_ff    <= (func_ff == FN_QUERY) && hit;
      end else if (cmd.pick) begin
         res_status_ff <= found ? ST_DONE : ST_NO_EDGE;
         res_nb_ff     <= found_idx;
         res_adj_ff    <= 1'b0;
      end
   end

   assign stat.go_mem  = is_mem && op_ok;
   assign stat.is_scan = func_ff inside {FN_FIRST, FN_NEXT};
   assign stat.mirror  = changes_u && !directed;

   assign res_status    = res_status_ff;
   assign res_neighbour = res_nb_ff;
   assign res_adjacent  = res_adj_ff;
   assign edge_count    = ecnt_ff;

endmodule

@@ hdl/adjacency_matrix_edge_store.sv @@
// Top level of the weighted adjacency-matrix edge store.
//
// Request channel (req_*): one word per operation: func, src_vertex, dst_vertex,
// edge_weight. A word is taken at a clock edge with req_valid high and req_stall low.
// Result channel (rsp_*): exactly one word per request: status, neighbour, adjacent
// and the edge count after the operation, held in an output register until taken
// (rsp_valid high, rsp_stall low).
// Register port (csr_*): index 0 is vertex_count, index 1 is directed. csr_ready is
// always high; write only while the block is idle.
// States after acceptance: decode, then done for clear, unused codes and invalid
// vertices; exec, done for query, and for insert or remove with no mirror write; exec,
// scan, done for first and next (masked row read, then a two-level lowest-bit search);
// exec, mirror read, mirror write, done for an insert or a removal of an edge in an
// undirected graph, which rewrites the mirror row. Rows live in a single-port memory,
// one row per access, updated by read-modify-write; req_stall stays high while a word
// is in work; a new word can be taken the cycle after the output register is loaded.
// Reset: all rows read as empty through per-row valid bits (no clearing pass), the
// edge count, vertex_count and directed return to zero, no result is pending.
// A stalled result holds; the block finishes the next word and waits for the register.
module adjacency_matrix_edge_store (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [ames_pkg::FUNC_W-1:0]           req_func,
   input  logic [ames_pkg::VID_W-1:0]            req_src_vertex,
   input  logic [ames_pkg::VID_W-1:0]            req_dst_vertex,
   input  logic signed [ames_pkg::WEIGHT_W-1:0]  req_edge_weight,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ames_pkg::STATUS_W-1:0]         rsp_status,
   output logic [ames_pkg::VID_W-1:0]            rsp_neighbour,
   output logic                                  rsp_adjacent,
   output logic [ames_pkg::ECNT_W-1:0]           rsp_edge_count,
   // register port
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ames_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ames_pkg::CSR_DATA_W-1:0]       csr_data
);
   import ames_pkg::*;

   logic [VCNT_W-1:0] vertex_count_ff;
   logic              directed_ff;
   logic [VCNT_W-1:0] eff_count;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [VID_W-1:0]    rsp_nb_ff;
   logic                rsp_adj_ff;
   logic [ECNT_W-1:0]   rsp_ecnt_ff;
   logic                rsp_free;

   ctrl_cmd_type        ctrl_cmd;
   dp_stat_type         dp_stat;
   logic [STATUS_W-1:0] res_status;
   logic [VID_W-1:0]    res_neighbour;
   logic                res_adjacent;
   logic [ECNT_W-1:0]   edge_count;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= '0;
         directed_ff     <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_VERTEX_COUNT: vertex_count_ff <= csr_data;
            CSR_DIRECTED:     directed_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Clamp the vertex count to the matrix size
   assign eff_count = (vertex_count_ff > VCNT_W'(MAX_VERTICES)) ?
                      VCNT_W'(MAX_VERTICES) : vertex_count_ff;

   // Output register: load on delivery, drop once taken
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl_cmd.deliver) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.deliver) begin
         rsp_status_ff <= res_status;
         rsp_nb_ff     <= res_neighbour;
         rsp_adj_ff    <= res_adjacent;
         rsp_ecnt_ff   <= edge_count;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_neighbour  = rsp_nb_ff;
   assign rsp_adjacent   = rsp_adj_ff;
   assign rsp_edge_count = rsp_ecnt_ff;

   ames_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_free  (rsp_free),
      .stat      (dp_stat),
      .cmd       (ctrl_cmd)
   );

   ames_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (ctrl_cmd),
      .stat            (dp_stat),
      .req_func        (req_func),
      .req_src_vertex  (req_src_vertex),
      .req_dst_vertex  (req_dst_vertex),
      .req_edge_weight (req_edge_weight),
      .vcount          (eff_count),
      .directed        (directed_ff),
      .res_status      (res_status),
      .res_neighbour   (res_neighbour),
      .res_adjacent    (res_adjacent),
      .edge_count      (edge_count)
   );

`ifndef SYNTHESIS
   a_deliver_free: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.deliver |-> rsp_free)
      else $error("result delivered into an occupied output register");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while a word is in work");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_DONE || rsp_status == ST_NO_EDGE ||
                     rsp_status == ST_BAD_VERTEX))
      else $error("undefined status code on result");

   a_neighbour_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_neighbour != '0)) |-> ((rsp_status == ST_DONE) && !rsp_adjacent))
      else $error("neighbour reported without a successful scan");
`endif

endmodule
